>>> src/dcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dryer cycle controller package
// Shared widths, event codes, profile defaults and channel payload types.
// ----------------------------------------------------------------------------
package dcc_pkg;

   localparam int NUM_PROFILES  = 4;
   localparam int PROFILE_SLOTS = 4;
   localparam int PROF_IDX_W    = 2;
   localparam int TEMP_REG_W    = 11;
   localparam int MINUTES_W     = 10;
   localparam int DURATION_W    = 26;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;
   localparam int NUM_CSR       = 8;

   localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

   // Event codes carried in req_type.
   localparam logic [2:0] EV_TICK         = 3'd0;
   localparam logic [2:0] EV_NEXT_PROFILE = 3'd1;
   localparam logic [2:0] EV_START        = 3'd2;
   localparam logic [2:0] EV_STOP         = 3'd3;
   localparam logic [2:0] EV_ALARM_TEMP   = 3'd4;
   localparam logic [2:0] EV_ALARM_SENSOR = 3'd5;
   localparam logic [2:0] EV_TO_SELECT    = 3'd6;
   localparam logic [2:0] EV_BEGIN        = 3'd7;

   // Reported state codes.
   localparam logic [2:0] SC_IDLE         = 3'd0;
   localparam logic [2:0] SC_SELECT       = 3'd1;
   localparam logic [2:0] SC_HEATING      = 3'd2;
   localparam logic [2:0] SC_REGULATION   = 3'd3;
   localparam logic [2:0] SC_COOLING      = 3'd4;
   localparam logic [2:0] SC_ALARM_TEMP   = 3'd5;
   localparam logic [2:0] SC_ALARM_SENSOR = 3'd6;

   localparam logic [TEMP_REG_W-1:0] TEMP_RESET [PROFILE_SLOTS] = '{
      11'd500, 11'd650, 11'd800, 11'd550
   };
   localparam logic [MINUTES_W-1:0] MINUTES_RESET = 10'd240;
   localparam logic [DURATION_W-1:0] DURATION_RESET = DURATION_W'(240 * 60000);

   typedef struct packed {
      logic [2:0]        req_type;
      logic [31:0]       time_ms;
      logic signed [11:0] temp_tenths;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]            state_code;
      logic [PROF_IDX_W-1:0] profile_index;
      logic [31:0]           elapsed_ms;
      logic [31:0]           remaining_ms;
   } rsp_payload_type;

   // Profile setpoints and precomputed durations in milliseconds.
   typedef struct packed {
      logic [PROFILE_SLOTS-1:0][TEMP_REG_W-1:0] temp;
      logic [PROFILE_SLOTS-1:0][DURATION_W-1:0] duration;
   } profile_set_type;

endpackage
`default_nettype wire

>>> src/dcc_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dryer cycle controller register file
// Profile setpoints and durations behind an APB-style port. The duration in
// milliseconds is computed once at the write so the sequencer needs no multiply.
// ----------------------------------------------------------------------------
module dcc_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [dcc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [dcc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [dcc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready,
   output dcc_pkg::profile_set_type           profiles
);
   import dcc_pkg::*;

   logic [TEMP_REG_W-1:0] temp_ff     [PROFILE_SLOTS];
   logic [MINUTES_W-1:0]  minutes_ff  [PROFILE_SLOTS];
   logic [DURATION_W-1:0] duration_ff [PROFILE_SLOTS];
   logic [2:0]            reg_index;
   logic [PROF_IDX_W-1:0] slot;
   logic                  wr_en;
   logic [DURATION_W-1:0] duration_in;

   assign csr_pready  = 1'b1;
   assign reg_index   = csr_paddr[4:2];
   assign slot        = reg_index[2:1];
   assign wr_en       = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign duration_in = DURATION_W'(csr_pwdata[MINUTES_W-1:0]) * DURATION_W'(MS_PER_MINUTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PROFILE_SLOTS; i++) begin
            temp_ff[i]     <= TEMP_RESET[i];
            minutes_ff[i]  <= MINUTES_RESET;
            duration_ff[i] <= DURATION_RESET;
         end
      end else if (wr_en) begin
         if (reg_index[0] == 1'b0) begin
            temp_ff[slot] <= csr_pwdata[TEMP_REG_W-1:0];
         end else begin
            minutes_ff[slot]  <= csr_pwdata[MINUTES_W-1:0];
            duration_ff[slot] <= duration_in;
         end
      end
   end

   always_comb begin
      if (reg_index[0] == 1'b0) begin
         csr_prdata = CSR_DATA_W'(temp_ff[slot]);
      end else begin
         csr_prdata = CSR_DATA_W'(minutes_ff[slot]);
      end
   end

   always_comb begin
      for (int i = 0; i < PROFILE_SLOTS; i++) begin
         profiles.temp[i]     = temp_ff[i];
         profiles.duration[i] = duration_ff[i];
      end
   end

endmodule
`default_nettype wire

>>> src/dryer_cycle_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dryer cycle controller
// Seven-state drying cycle sequencer with per-profile setpoint and duration.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the req_ channel is one event with a millisecond timestamp and a
// temperature in signed tenths of a degree. Every item produces exactly one
// rsp_ item with the state, the selected profile and the elapsed and remaining
// cycle time after the event has been applied.
// The event is applied and the result computed in the cycle the item is
// accepted and registered for rsp_; throughput is one item per cycle while
// req_ready is high, set by the single state update path.
// The result register is backed by a one-entry skid stage, so one more item
// is taken while a result waits; req_ready drops only when the skid stage is
// also occupied, and rises again the cycle after the receiver takes a result.
// Synchronous reset returns the sequencer to idle with profile 1 selected,
// empties both output stages and restores the default profile table. The user
// writes profile registers via csr_ only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module dryer_cycle_controller_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire dcc_pkg::req_payload_type      req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output dcc_pkg::rsp_payload_type           rsp_payload,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [dcc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [dcc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [dcc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);
   import dcc_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE         = 7'b0000001,
      S_SELECT       = 7'b0000010,
      S_HEATING      = 7'b0000100,
      S_REGULATION   = 7'b0001000,
      S_COOLING      = 7'b0010000,
      S_ALARM_TEMP   = 7'b0100000,
      S_ALARM_SENSOR = 7'b1000000
   } cycle_state_type;

   profile_set_type       profiles;

   cycle_state_type       state_ff, state_in;
   logic [PROF_IDX_W-1:0] sel_ff, sel_in, sel_next;
   logic [31:0]           start_ff, start_in;
   logic [DURATION_W-1:0] target_ff, target_in;

   rsp_payload_type       out_ff, skid_ff, result;
   logic                  out_valid_ff, skid_valid_ff;

   logic                  accept, take, load_target;
   logic [31:0]           tick_elapsed, out_elapsed;
   logic signed [12:0]    reach_thresh;
   logic                  reached, expired, cooled, running;

   dcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .profiles    (profiles)
   );

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;
   assign take      = out_valid_ff & rsp_ready;

   // Tick conditions, evaluated against the state held before this item.
   assign tick_elapsed = req_payload.time_ms - start_ff;
   assign expired      = tick_elapsed >= 32'(target_ff);
   assign reach_thresh = $signed({2'b00, profiles.temp[sel_ff]}) - 13'sd10;
   assign reached      = $signed({req_payload.temp_tenths[11], req_payload.temp_tenths})
                         >= reach_thresh;
   assign cooled       = req_payload.temp_tenths <= 12'sd350;

   assign sel_next = (sel_ff == PROF_IDX_W'(NUM_PROFILES - 1)) ? '0 : sel_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      start_in    = start_ff;
      load_target = 1'b0;
      unique case (req_payload.req_type)
         EV_TICK: begin
            unique case (state_ff)
               S_HEATING: begin
                  if (reached) state_in = S_REGULATION;
                  if (expired) state_in = S_COOLING;
               end
               S_REGULATION: begin
                  if (expired) state_in = S_COOLING;
               end
               S_COOLING: begin
                  if (cooled) state_in = S_IDLE;
               end
               default: ;
            endcase
         end
         EV_NEXT_PROFILE: begin
            if (state_ff == S_IDLE || state_ff == S_SELECT) begin
               sel_in      = sel_next;
               load_target = 1'b1;
               state_in    = S_SELECT;
            end
         end
         EV_START: begin
            if (state_ff == S_SELECT || state_ff == S_IDLE || state_ff == S_COOLING) begin
               state_in    = S_HEATING;
               start_in    = req_payload.time_ms;
               load_target = 1'b1;
            end
         end
         EV_STOP: begin
            if (state_ff == S_HEATING || state_ff == S_REGULATION) begin
               state_in = S_COOLING;
            end else if (state_ff == S_COOLING || state_ff == S_ALARM_TEMP ||
                         state_ff == S_ALARM_SENSOR) begin
               state_in = S_SELECT;
            end
         end
         EV_ALARM_TEMP:   state_in = S_ALARM_TEMP;
         EV_ALARM_SENSOR: state_in = S_ALARM_SENSOR;
         EV_TO_SELECT:    state_in = S_SELECT;
         EV_BEGIN: begin
            state_in    = S_SELECT;
            load_target = 1'b1;
         end
         default: ;
      endcase
      target_in = load_target ? profiles.duration[sel_in] : target_ff;
   end

   // Result fields reflect the state after the event, at this item's time.
   assign running     = (state_in == S_HEATING) || (state_in == S_REGULATION);
   assign out_elapsed = req_payload.time_ms - start_in;

   always_comb begin
      unique case (state_in)
         S_IDLE:         result.state_code = SC_IDLE;
         S_SELECT:       result.state_code = SC_SELECT;
         S_HEATING:      result.state_code = SC_HEATING;
         S_REGULATION:   result.state_code = SC_REGULATION;
         S_COOLING:      result.state_code = SC_COOLING;
         S_ALARM_TEMP:   result.state_code = SC_ALARM_TEMP;
         S_ALARM_SENSOR: result.state_code = SC_ALARM_SENSOR;
         default:        result.state_code = SC_IDLE;
      endcase
      result.profile_index = sel_in;
      if (running) begin
         result.elapsed_ms = out_elapsed;
         if (out_elapsed < 32'(target_in)) begin
            result.remaining_ms = 32'(target_in) - out_elapsed;
         end else begin
            result.remaining_ms = '0;
         end
      end else begin
         result.elapsed_ms   = '0;
         result.remaining_ms = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sel_ff    <= PROF_IDX_W'(1);
         start_ff  <= '0;
         target_ff <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         sel_ff    <= sel_in;
         start_ff  <= start_in;
         target_ff <= target_in;
      end
   end

   // Output register with a one-entry skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (accept && (take || !out_valid_ff)) begin
         out_ff <= result;
      end
      if (accept && out_valid_ff && !take) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds an item while the output register is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      accept && out_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("item accepted during a stall was not kept in the skid stage");

   a_idle_times_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_payload.state_code == SC_HEATING ||
                     rsp_payload.state_code == SC_REGULATION)
      |-> rsp_payload.elapsed_ms == 32'd0 && rsp_payload.remaining_ms == 32'd0)
      else $error("nonzero cycle time reported outside a running state");

   a_alarm_entry: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.req_type == EV_ALARM_TEMP |=> state_ff == S_ALARM_TEMP)
      else $error("overtemp alarm item did not enter the alarm state");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_dryer_cycle_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dryer cycle controller testbench
// Drives event items with timestamps and temperatures through the req_ channel,
// rewrites the profile table over the csr_ port between phases, and checks
// every rsp_ item against a directed expectation or a sequencer model in the
// testbench. Both channels stall at random in bursts, except in the final phase.
// ----------------------------------------------------------------------------
module tb_dryer_cycle_controller_unit;
   import dcc_pkg::*;

   localparam int APPROACH_TENTHS  = 10;
   localparam int COOL_DONE_TENTHS = 350;
   localparam int RANDOM_PHASES    = 7;
   localparam int ITEMS_PER_PHASE  = 160;

   typedef struct {
      logic [2:0]      ev;
      logic [31:0]     ms;
      int              temp;
      bit              typed;
      rsp_payload_type want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Sequencer model state and its copy of the profile table.
   logic [2:0]            seq_state;
   logic [PROF_IDX_W-1:0] sel_prof;
   logic [31:0]           cyc_start;
   logic [31:0]           cyc_target;
   logic [TEMP_REG_W-1:0] prof_setpoint [PROFILE_SLOTS];
   logic [MINUTES_W-1:0]  prof_minutes_cfg [PROFILE_SLOTS];

   rsp_payload_type status_q [$];
   plan_row_type    plan [$];
   logic [31:0]     wall_ms;
   int              n_bad = 0;
   int              n_shown = 0;
   int              tx_calm = 0;
   bit              quiet = 1'b0;

   dryer_cycle_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic plan_row_type plan_row(logic [2:0] ev, logic [31:0] ms, int temp,
                                             bit typed, logic [2:0] st, logic [1:0] pf,
                                             logic [31:0] el, logic [31:0] rem);
      plan_row_type r;
      r.ev    = ev;
      r.ms    = ms;
      r.temp  = temp;
      r.typed = typed;
      r.want  = '{state_code: st, profile_index: pf, elapsed_ms: el, remaining_ms: rem};
      return r;
   endfunction

   function automatic logic [31:0] profile_duration(logic [PROF_IDX_W-1:0] idx);
      return 32'(prof_minutes_cfg[idx]) * 32'(MS_PER_MINUTE);
   endfunction

   function automatic bit cycle_running();
      return seq_state == SC_HEATING || seq_state == SC_REGULATION;
   endfunction

   // Applies one event to the model and returns the status it reports.
   task automatic step_sequencer(input req_payload_type p, output rsp_payload_type r);
      logic [31:0] el;
      int          t;
      int          setp;
      t    = $signed(p.temp_tenths);
      setp = int'(prof_setpoint[sel_prof]);
      el   = p.time_ms - cyc_start;
      case (p.req_type)
         EV_TICK: begin
            case (seq_state)
               SC_HEATING: begin
                  if (t >= setp - APPROACH_TENTHS) seq_state = SC_REGULATION;
                  // Timeout wins over reaching the setpoint.
                  if (el >= cyc_target) seq_state = SC_COOLING;
               end
               SC_REGULATION: begin
                  if (el >= cyc_target) seq_state = SC_COOLING;
               end
               SC_COOLING: begin
                  if (t <= COOL_DONE_TENTHS) seq_state = SC_IDLE;
               end
               default: ;
            endcase
         end
         EV_NEXT_PROFILE: begin
            if (seq_state == SC_IDLE || seq_state == SC_SELECT) begin
               sel_prof   = PROF_IDX_W'((int'(sel_prof) + 1) % NUM_PROFILES);
               cyc_target = profile_duration(sel_prof);
               seq_state  = SC_SELECT;
            end
         end
         EV_START: begin
            if (seq_state == SC_SELECT || seq_state == SC_IDLE || seq_state == SC_COOLING) begin
               seq_state  = SC_HEATING;
               cyc_start  = p.time_ms;
               cyc_target = profile_duration(sel_prof);
            end
         end
         EV_STOP: begin
            if (cycle_running()) seq_state = SC_COOLING;
            else if (seq_state == SC_COOLING || seq_state == SC_ALARM_TEMP ||
                     seq_state == SC_ALARM_SENSOR) seq_state = SC_SELECT;
         end
         EV_ALARM_TEMP:   seq_state = SC_ALARM_TEMP;
         EV_ALARM_SENSOR: seq_state = SC_ALARM_SENSOR;
         EV_TO_SELECT:    seq_state = SC_SELECT;
         EV_BEGIN: begin
            seq_state  = SC_SELECT;
            cyc_target = profile_duration(sel_prof);
         end
         default: ;
      endcase
      r.state_code    = seq_state;
      r.profile_index = sel_prof;
      r.elapsed_ms    = '0;
      r.remaining_ms  = '0;
      if (cycle_running()) begin
         el           = p.time_ms - cyc_start;
         r.elapsed_ms = el;
         if (el < cyc_target) r.remaining_ms = cyc_target - el;
      end
   endtask

   // Presents one item, waits for it to be taken, then records its expected status.
   task automatic send_item(input req_payload_type p, input bit typed,
                            input rsp_payload_type want);
      rsp_payload_type r;
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      step_sequencer(p, r);
      status_q.push_back(typed ? want : r);
   endtask

   task automatic pace_sender();
      if (tx_calm > 0) tx_calm--;
      else if ($urandom_range(0, 29) == 0) tx_calm = $urandom_range(20, 60);
      if (!quiet && tx_calm == 0 && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; psel is left high for a following write.
   task automatic csr_write(input int idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx % 2 == 0) prof_setpoint[idx / 2] = val[TEMP_REG_W-1:0];
      else prof_minutes_cfg[idx / 2] = val[MINUTES_W-1:0];
   endtask

   task automatic make_random_item(output req_payload_type p);
      int          roll;
      int          thr;
      int          tv;
      logic [2:0]  ev;
      logic [31:0] tv_bits;
      roll = $urandom_range(0, 99);
      if (roll < 65) wall_ms += $urandom_range(0, 3000);
      else if (roll < 85) wall_ms += $urandom_range(0, cyc_target / 4 + 1);
      else if (roll < 93 && cycle_running()) wall_ms = cyc_start + cyc_target - $urandom_range(0, 1);
      else wall_ms = $urandom();

      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) ev = 3'($urandom_range(0, 7));
      else begin
         case (seq_state)
            SC_IDLE, SC_SELECT: begin
               if (roll < 30) ev = EV_NEXT_PROFILE;
               else if (roll < 70) ev = EV_START;
               else if (roll < 85) ev = EV_BEGIN;
               else ev = EV_TICK;
            end
            SC_HEATING: begin
               if (roll < 80) ev = EV_TICK;
               else if (roll < 90) ev = EV_STOP;
               else if (roll < 95) ev = EV_ALARM_TEMP;
               else ev = EV_ALARM_SENSOR;
            end
            SC_REGULATION: begin
               if (roll < 85) ev = EV_TICK;
               else if (roll < 95) ev = EV_STOP;
               else ev = EV_TO_SELECT;
            end
            SC_COOLING: begin
               if (roll < 70) ev = EV_TICK;
               else if (roll < 85) ev = EV_START;
               else ev = EV_STOP;
            end
            default: begin
               if (roll < 40) ev = EV_STOP;
               else if (roll < 70) ev = EV_TO_SELECT;
               else ev = EV_TICK;
            end
         endcase
      end

      // Temperatures cluster around whichever threshold the current state compares.
      thr = int'(prof_setpoint[sel_prof]) - APPROACH_TENTHS;
      if ($urandom_range(0, 9) == 0) begin
         tv_bits = $urandom();
         tv      = int'(tv_bits[11:0]);
      end else if (seq_state == SC_HEATING) tv = thr + $urandom_range(0, 40) - 30;
      else if (seq_state == SC_COOLING) tv = COOL_DONE_TENTHS + $urandom_range(0, 30) - 20;
      else tv = $urandom_range(0, 2400) - 400;

      p.req_type    = ev;
      p.time_ms     = wall_ms;
      p.temp_tenths = 12'(tv);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_q.size() == 0) begin
            n_bad++;
            if (n_shown < 10) begin
               n_shown++;
               $display("unexpected result: state %0d profile %0d elapsed %0d remaining %0d",
                        rsp_payload.state_code, rsp_payload.profile_index,
                        rsp_payload.elapsed_ms, rsp_payload.remaining_ms);
            end
         end else begin
            want = status_q.pop_front();
            if (rsp_payload.state_code !== want.state_code ||
                rsp_payload.profile_index !== want.profile_index ||
                rsp_payload.elapsed_ms !== want.elapsed_ms ||
                rsp_payload.remaining_ms !== want.remaining_ms) begin
               n_bad++;
               if (n_shown < 10) begin
                  n_shown++;
                  $display("mismatch at %0t: expected state %0d profile %0d elapsed %0d remaining %0d",
                           $realtime, want.state_code, want.profile_index, want.elapsed_ms,
                           want.remaining_ms);
                  $display("                 got state %0d profile %0d elapsed %0d remaining %0d",
                           rsp_payload.state_code, rsp_payload.profile_index,
                           rsp_payload.elapsed_ms, rsp_payload.remaining_ms);
               end
            end
         end
      end
   end

   initial begin
      int calm;
      calm      = 0;
      rsp_ready = 1'b1;
      forever begin
         @(posedge clock);
         if (calm > 0) calm--;
         else if ($urandom_range(0, 29) == 0) calm = $urandom_range(20, 60);
         if (!quiet && calm == 0 && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_payload_type p;
      logic [31:0]     v;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      seq_state   = SC_IDLE;
      sel_prof    = 2'd1;
      cyc_start   = '0;
      cyc_target  = '0;
      wall_ms     = '0;
      for (int i = 0; i < PROFILE_SLOTS; i++) begin
         prof_setpoint[i]    = TEMP_RESET[i];
         prof_minutes_cfg[i] = MINUTES_RESET;
      end

      // Default table: profile 1 is 65.0 degrees for 240 minutes (14400000 ms).
      plan.push_back(plan_row(EV_TICK, 32'd0, 0, 1, SC_IDLE, 2'd1, 32'd0, 32'd0));
      plan.push_back(plan_row(EV_TICK, 32'hFFFF_FFFF, -2048, 1, SC_IDLE, 2'd1, 32'd0, 32'd0));
      plan.push_back(plan_row(EV_START, 32'd1000, 2047, 1, SC_HEATING, 2'd1, 32'd0, 32'd14400000));
      plan.push_back(plan_row(EV_TICK, 32'd2000, -400, 1, SC_HEATING, 2'd1, 32'd1000,
                              32'd14399000));
      plan.push_back(plan_row(EV_TICK, 32'd3000, 639, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_TICK, 32'd4000, 640, 1, SC_REGULATION, 2'd1, 32'd3000,
                              32'd14397000));
      plan.push_back(plan_row(EV_TICK, 32'd14400999, 2000, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_TICK, 32'd14401000, 0, 1, SC_COOLING, 2'd1, 32'd0, 32'd0));
      plan.push_back(plan_row(EV_TICK, 32'd14402000, 351, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_TICK, 32'd14403000, 350, 1, SC_IDLE, 2'd1, 32'd0, 32'd0));
      plan.push_back(plan_row(EV_NEXT_PROFILE, 32'd1, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_NEXT_PROFILE, 32'd2, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_NEXT_PROFILE, 32'd3, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_NEXT_PROFILE, 32'd4, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_ALARM_TEMP, 32'd5, 0, 1, SC_ALARM_TEMP, 2'd1, 32'd0, 32'd0));
      plan.push_back(plan_row(EV_NEXT_PROFILE, 32'd6, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_STOP, 32'd7, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_ALARM_SENSOR, 32'd8, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_START, 32'd9, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_TO_SELECT, 32'd10, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_BEGIN, 32'd11, 0, 0, '0, '0, '0, '0));
      // The cycle starts just below the wrap of the millisecond counter.
      plan.push_back(plan_row(EV_START, 32'hFFFF_FF00, 0, 1, SC_HEATING, 2'd1, 32'd0,
                              32'd14400000));
      plan.push_back(plan_row(EV_TICK, 32'h0000_0100, 2047, 1, SC_REGULATION, 2'd1, 32'd512,
                              32'd14399488));
      plan.push_back(plan_row(EV_START, 32'h0000_0200, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_STOP, 32'h0000_0300, 0, 0, '0, '0, '0, '0));
      plan.push_back(plan_row(EV_START, 32'h0000_0400, 0, 0, '0, '0, '0, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         p.req_type    = plan[i].ev;
         p.time_ms     = plan[i].ms;
         p.temp_tenths = 12'(plan[i].temp);
         send_item(p, plan[i].typed, plan[i].want);
         pace_sender();
      end
      wall_ms = p.time_ms;

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph > 0) begin
            drain_results();
            for (int idx = 0; idx < NUM_CSR; idx++) begin
               case (ph)
                  1: v = 32'h0;
                  2: v = 32'hFFFF_FFFF;
                  3: v = (idx % 2 == 0) ? 32'd2000 : 32'd1;
                  4: begin
                     v = $urandom();
                     if (idx % 2 == 0) v[TEMP_REG_W-1:0] = TEMP_REG_W'($urandom_range(0, 2000));
                     else v[MINUTES_W-1:0] = MINUTES_W'($urandom_range(0, 3));
                  end
                  5: v = $urandom();
                  default: v = (idx % 2 == 0) ? $urandom_range(300, 900) : $urandom_range(0, 2);
               endcase
               csr_write(idx, v);
            end
            csr_psel    <= 1'b0;
            csr_penable <= 1'b0;
            csr_pwrite  <= 1'b0;
            @(posedge clock);
         end
         if (ph == RANDOM_PHASES - 1) quiet = 1'b1;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            make_random_item(p);
            send_item(p, 1'b0, '0);
            // Halfway through each busy phase the sender holds off until all results are in.
            if (k == ITEMS_PER_PHASE / 2 && !quiet) drain_results();
            else pace_sender();
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (n_bad == 0 && status_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
